[hdl/adcmaf_pkg.sv]
// Shared types, constants and helpers of the ADC median / average filter.
package adcmaf_pkg;

   localparam int CHANNEL_W = 4;
   localparam int SAMPLE_W  = 12;
   localparam int MODE_W    = 3;
   localparam int SCAN_W    = 4;

   localparam int CHANNELS_DEF    = 16;
   localparam int MAX_SLOTS_DEF   = 64;
   localparam int SAMPLE_BITS_DEF = 12;

   typedef enum logic [MODE_W-1:0] {
      MODE_NEWEST  = 3'd0,
      MODE_MEDIAN3 = 3'd1,
      MODE_MEAN4   = 3'd2,
      MODE_MEDMED  = 3'd3,
      MODE_MEANMED = 3'd4,
      MODE_MEAN64  = 3'd5
   } mode_type;

   localparam mode_type MODE_RESET = MODE_MEDIAN3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel_out;
      logic [SAMPLE_W-1:0]  filtered;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic              accept;
      logic              update;
      logic              scan_rd;
      logic [SCAN_W-1:0] scan_idx;
      logic              load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_in_range;
      logic item_in_range;
   } sts_type;

   // number of stored slots a mode reads, from slot 0 upward
   function automatic logic [SCAN_W-1:0] scan_len(input mode_type mode);
      logic [SCAN_W-1:0] len;
      case (mode)
         MODE_MEDIAN3: len = 4'd3;
         MODE_MEAN4:   len = 4'd4;
         MODE_MEDMED:  len = 4'd9;
         MODE_MEANMED: len = 4'd12;
         default:      len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

[hdl/adcmaf_ctrl.sv]
// Sequencer of the ADC filter: accepts a word, steps the slot scan, loads the result.
module adcmaf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  adcmaf_pkg::mode_type mode,
   input  adcmaf_pkg::sts_type sts,
   output adcmaf_pkg::cmd_type cmd
);

   adcmaf_pkg::state_type             state_ff, state_in;
   logic [adcmaf_pkg::SCAN_W-1:0]     idx_ff, idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [adcmaf_pkg::SCAN_W-1:0]     len;
   logic                              rsp_free;

   assign len       = adcmaf_pkg::scan_len(mode);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != adcmaf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= adcmaf_pkg::ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.scan_idx = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         adcmaf_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.req_in_range ? adcmaf_pkg::ST_UPDATE : adcmaf_pkg::ST_FINISH;
            end
         end
         adcmaf_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            idx_in     = '0;
            state_in   = (len == '0) ? adcmaf_pkg::ST_FINISH : adcmaf_pkg::ST_SCAN;
         end
         adcmaf_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == len - 1'b1) begin
               state_in = adcmaf_pkg::ST_WAIT;
            end
         end
         adcmaf_pkg::ST_WAIT: begin
            state_in = adcmaf_pkg::ST_FINISH;
         end
         adcmaf_pkg::ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = adcmaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adcmaf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/adcmaf_datapath.sv]
// Sample store, per-channel ring pointers and sums, median and mean arithmetic.
module adcmaf_datapath #(
   parameter int CHANNELS    = adcmaf_pkg::CHANNELS_DEF,
   parameter int MAX_SLOTS   = adcmaf_pkg::MAX_SLOTS_DEF,
   parameter int SAMPLE_BITS = adcmaf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  adcmaf_pkg::req_type req_data,
   input  adcmaf_pkg::mode_type mode,
   input  adcmaf_pkg::cmd_type cmd,
   output adcmaf_pkg::sts_type sts,
   output adcmaf_pkg::rsp_type rsp_data
);

   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int ADDR_W    = CH_W + SLOT_W;
   localparam int MEM_DEPTH = CHANNELS * (1 << SLOT_W);
   localparam int SUM_W     = SAMPLE_BITS + SLOT_W;
   localparam int ACC_W     = SAMPLE_BITS + 2;
   localparam int SW        = adcmaf_pkg::SAMPLE_W;

   function automatic logic [SAMPLE_BITS-1:0] med3(input logic [SAMPLE_BITS-1:0] a,
                                                   input logic [SAMPLE_BITS-1:0] b,
                                                   input logic [SAMPLE_BITS-1:0] c);
      logic [SAMPLE_BITS-1:0] lo, hi, m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) begin
         m = lo;
      end else if (c >= hi) begin
         m = hi;
      end else begin
         m = c;
      end
      return m;
   endfunction

   logic [SAMPLE_BITS-1:0] sample_mem [MEM_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]      rd_addr, wr_addr;

   logic [SLOT_W-1:0]      write_slot_ff [CHANNELS];
   logic                   wrapped_ff    [CHANNELS];
   logic [SUM_W-1:0]       sum_ff        [CHANNELS];

   logic [adcmaf_pkg::CHANNEL_W-1:0] ch_ff;
   logic [SAMPLE_BITS-1:0]           s_ff;
   logic                             in_range_ff;

   logic                             proc_valid_ff;
   logic [adcmaf_pkg::SCAN_W-1:0]    proc_idx_ff;
   logic [1:0]                       ph_ff, grp_ff;
   logic [SAMPLE_BITS-1:0]           a_ff, b_ff;
   logic [SAMPLE_BITS-1:0]           gm_ff [3];
   logic [ACC_W-1:0]                 acc_ff;
   adcmaf_pkg::rsp_type              rsp_ff;

   logic [CH_W-1:0]        req_chi, chi;
   logic                   req_in_range;
   logic [SAMPLE_BITS-1:0] req_s;
   logic [SLOT_W-1:0]      req_pos, pos, slot_in;
   logic                   wrapped_in, last_slot;
   logic [SAMPLE_BITS-1:0] old_val, d_val, med_val, res;
   logic [SUM_W-1:0]       sum_in;
   logic [SLOT_W-1:0]      proc_slot;
   logic [SW-1:0]          filtered;

   assign req_chi      = req_data.channel[CH_W-1:0];
   assign req_in_range = 32'(req_data.channel) < CHANNELS;
   assign req_s        = SAMPLE_BITS'((SW + SAMPLE_BITS)'(req_data.sample));
   assign req_pos      = req_in_range ? write_slot_ff[req_chi] : '0;
   assign chi          = ch_ff[CH_W-1:0];

   assign sts.req_in_range  = req_in_range;
   assign sts.item_in_range = in_range_ff;

   // ring pointer and running sum advance for the current item
   assign pos        = write_slot_ff[chi];
   assign last_slot  = (32'(pos) == MAX_SLOTS - 1);
   assign slot_in    = last_slot ? '0 : pos + 1'b1;
   assign wrapped_in = wrapped_ff[chi] || last_slot;
   assign old_val    = wrapped_ff[chi] ? rd_data_ff : '0;
   assign sum_in     = sum_ff[chi] - SUM_W'(old_val) + SUM_W'(s_ff);

   assign wr_addr = {chi, pos};
   assign rd_addr = cmd.accept ? {req_chi, req_pos}
                               : {chi, SLOT_W'(cmd.scan_idx)};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sample_mem[wr_addr] <= s_ff;
      end
      rd_data_ff <= sample_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            write_slot_ff[i] <= '0;
            wrapped_ff[i]    <= 1'b0;
            sum_ff[i]        <= '0;
         end
      end else if (cmd.update) begin
         write_slot_ff[chi] <= slot_in;
         wrapped_ff[chi]    <= wrapped_in;
         sum_ff[chi]        <= sum_in;
      end
   end

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_range_ff <= 1'b0;
      end else if (cmd.accept) begin
         in_range_ff <= req_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff <= req_data.channel;
         s_ff  <= req_s;
      end
   end

   // scan: read data arrives in the cycle after the address
   assign proc_slot = SLOT_W'(proc_idx_ff);
   assign d_val     = (wrapped_ff[chi] || (proc_slot < write_slot_ff[chi])) ? rd_data_ff : '0;
   assign med_val   = med3(a_ff, b_ff, d_val);

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_valid_ff <= 1'b0;
      end else begin
         proc_valid_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= cmd.scan_idx;
      if (cmd.update) begin
         ph_ff  <= '0;
         grp_ff <= '0;
         acc_ff <= '0;
      end else if (proc_valid_ff) begin
         case (ph_ff)
            2'd0: begin
               a_ff  <= d_val;
               ph_ff <= 2'd1;
            end
            2'd1: begin
               b_ff  <= d_val;
               ph_ff <= 2'd2;
            end
            default: begin
               ph_ff  <= 2'd0;
               grp_ff <= grp_ff + 1'b1;
               if (grp_ff != 2'd3) begin
                  gm_ff[grp_ff] <= med_val;
               end
            end
         endcase
         if (mode == adcmaf_pkg::MODE_MEAN4) begin
            acc_ff <= acc_ff + ACC_W'(d_val);
         end else if (ph_ff == 2'd2) begin
            acc_ff <= acc_ff + ACC_W'(med_val);
         end
      end
   end

   always_comb begin
      case (mode)
         adcmaf_pkg::MODE_MEDIAN3: res = gm_ff[0];
         adcmaf_pkg::MODE_MEAN4:   res = acc_ff[ACC_W-1:2];
         adcmaf_pkg::MODE_MEDMED:  res = med3(gm_ff[0], gm_ff[1], gm_ff[2]);
         adcmaf_pkg::MODE_MEANMED: res = acc_ff[ACC_W-1:2];
         adcmaf_pkg::MODE_MEAN64:  res = SAMPLE_BITS'(sum_ff[chi] >> 6);
         default:                  res = s_ff;
      endcase
   end

   assign filtered = in_range_ff ? SW'((SW + SAMPLE_BITS)'(res)) : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.channel_out <= ch_ff;
         rsp_ff.filtered    <= filtered;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[hdl/adc_median_average_filter.sv]
// Top level of the ADC median / moving-average filter.
//
//   port group   dir  handshake            word
//   req_*        in   req_valid/req_stall  channel, sample
//   rsp_*        out  rsp_valid/rsp_stall  channel_out, filtered
//   csr_*        in   csr_valid/csr_ready  filter_mode (3 bits)
//
// An in-range word steps through accept, ring update and result load in modes 0 and 5;
// the others add a scan of N slots, read through the single store read port, and a wait:
// 3 (median3), 4 (mean4), 9 (median of medians), 12 (mean of medians).
// A word for a channel beyond CHANNELS goes from accept to the result load and reports zero.
// Reset is synchronous; the store needs no clearing pass: per-channel fill pointers
// mask slots never written. A stalled result holds the sequencer before its load.
module adc_median_average_filter #(
   parameter int CHANNELS    = adcmaf_pkg::CHANNELS_DEF,
   parameter int MAX_SLOTS   = adcmaf_pkg::MAX_SLOTS_DEF,
   parameter int SAMPLE_BITS = adcmaf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  adcmaf_pkg::req_type             req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output adcmaf_pkg::rsp_type             rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [adcmaf_pkg::MODE_W-1:0]   csr_wdata
);

   adcmaf_pkg::mode_type mode_ff;
   adcmaf_pkg::cmd_type  cmd;
   adcmaf_pkg::sts_type  sts;

   // mode register: to be written only between words; the block does not enforce this, so always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= adcmaf_pkg::MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= adcmaf_pkg::mode_type'(csr_wdata);
      end
   end

   // sequencer: accept, ring update, slot scan, result load
   adcmaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .mode      (mode_ff),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store, pointers, sums and filter arithmetic
   adcmaf_datapath #(
      .CHANNELS    (CHANNELS),
      .MAX_SLOTS   (MAX_SLOTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .mode     (mode_ff),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // an in-range word always goes straight to the ring update
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && sts.req_in_range |=> cmd.update)
      else $error("accepted word did not move to ring update");

   // a result load never overwrites a word still waiting at the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_valid || !rsp_stall)
      else $error("result loaded over an untaken word");

   // a channel beyond the configured count reports zero
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && !sts.item_in_range |=> rsp_data.filtered == '0)
      else $error("out-of-range channel gave a nonzero result");

   // only one word in flight: no accept while the ring update runs
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !cmd.accept && !cmd.load_rsp)
      else $error("overlapping item steps");

endmodule
